### rtl/signal_pending_mask_delivery_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signal pending and delivery block.
// Each macro expands to one labelled concurrent assertion with a reset guard.
// ----------------------------------------------------------------------------
`ifndef SIGNAL_PENDING_MASK_DELIVERY_DEFINES_SVH
`define SIGNAL_PENDING_MASK_DELIVERY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPMD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/spmd_pkg.sv
// ----------------------------------------------------------------------------
// spmd_pkg
// Types, codes and helper functions shared by the signal pending and
// delivery block.
// ----------------------------------------------------------------------------
package spmd_pkg;

  // Request kinds.
  localparam logic [2:0] K_SET     = 3'd0;
  localparam logic [2:0] K_HOST    = 3'd1;
  localparam logic [2:0] K_RAISE   = 3'd2;
  localparam logic [2:0] K_PICK    = 3'd3;
  localparam logic [2:0] K_RESTORE = 3'd4;

  // Handler kinds.
  localparam logic [1:0] HK_DEFAULT = 2'd0;
  localparam logic [1:0] HK_IGNORE  = 2'd1;

  // Result events.
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_DELIVER = 2'd1;
  localparam logic [1:0] EV_TERM    = 2'd2;
  localparam logic [1:0] EV_NOTIFY  = 2'd3;

  // Signals whose default action is to do nothing.
  localparam logic [6:0] SIG_CHLD  = 7'd17;
  localparam logic [6:0] SIG_CONT  = 7'd18;
  localparam logic [6:0] SIG_URG   = 7'd23;
  localparam logic [6:0] SIG_WINCH = 7'd28;

  localparam logic [7:0] EXIT_BASE = 8'd128;

  // Host to guest renumbering for host signals below 32.
  localparam logic [4:0] HOST_MAP [32] = '{
    5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,
    5'd8,  5'd9,  5'd7,  5'd11, 5'd31, 5'd13, 5'd14, 5'd15,
    5'd23, 5'd19, 5'd20, 5'd18, 5'd17, 5'd21, 5'd22, 5'd29,
    5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd10, 5'd12
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [6:0]  signo;
    logic [1:0]  handler_kind;
    logic        nodefer;
    logic [63:0] mask_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [6:0]  out_signo;
    logic [7:0]  term_code;
    logic [63:0] blocked_now;
  } out_word_t;

  // One action table entry.
  typedef struct packed {
    logic [1:0]  handler_kind;
    logic        nodefer;
    logic [63:0] mask;
  } act_entry_t;

  // Result of the lowest-signal search.
  typedef struct packed {
    logic        found;
    logic [6:0]  signo;
    logic [63:0] onehot;
    logic [63:0] lowmask;
  } pick_t;

  // Guest number for a host signal number.
  function automatic logic [6:0] host_to_guest(input logic [6:0] s);
    logic [6:0] g;
    if (s < 7'd32) begin
      g = {2'b00, HOST_MAP[s[4:0]]};
    end else begin
      g = s;
    end
    return g;
  endfunction

  // Mask bit owned by signal s (bit s minus one).
  function automatic logic [63:0] sig_bit(input logic [6:0] s);
    logic [5:0] sh;
    sh = 6'(s - 7'd1);
    return 64'd1 << sh;
  endfunction

endpackage

### rtl/spmd_act_mem.sv
// ----------------------------------------------------------------------------
// spmd_act_mem
// Per-signal action table: one write port, one registered read port, and a
// valid bit per entry so that unwritten entries read as the default action.
// ----------------------------------------------------------------------------
module spmd_act_mem #(
  parameter int NUM_SIGNALS = 64,
  localparam int AW = $clog2(NUM_SIGNALS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  spmd_pkg::act_entry_t wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output spmd_pkg::act_entry_t rdata
);
  import spmd_pkg::*;

  act_entry_t             mem [NUM_SIGNALS];
  logic [NUM_SIGNALS-1:0] valid_r;
  act_entry_t             rd_data_r;
  logic                   rd_valid_r;

  // Storage array: write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  // Valid bits, cleared together at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (re) begin
        rd_valid_r <= valid_r[raddr];
      end
    end
  end

  // An entry never written reads as the default action with an empty mask.
  assign rdata = rd_valid_r ? rd_data_r : '0;

endmodule

### rtl/spmd_pick.sv
// ----------------------------------------------------------------------------
// spmd_pick
// Finds the lowest pending, unblocked signal with a custom handler and the
// range of lower signals that a delivery check drops.
// ----------------------------------------------------------------------------
module spmd_pick #(
  parameter int NUM_SIGNALS = 64
) (
  input  logic [63:0]     pending,
  input  logic [63:0]     blocked,
  input  logic [63:0]     custom,
  output spmd_pkg::pick_t pick
);
  import spmd_pkg::*;

  localparam logic [63:0] SIG_LIMIT = {64{1'b1}} >> (64 - NUM_SIGNALS);

  logic [63:0] cand;
  logic [63:0] onehot;
  logic [6:0]  idx;

  // Isolate the lowest candidate bit.
  assign cand   = pending & ~blocked & custom & SIG_LIMIT;
  assign onehot = cand & (~cand + 64'd1);

  // Encode the one-hot bit into a signal number.
  always_comb begin
    idx = '0;
    for (int i = 0; i < 64; i++) begin
      if (onehot[i]) begin
        idx = idx | 7'(i + 1);
      end
    end
  end

  // The mask covers the chosen bit and all below it; with no candidate it
  // covers every bit.
  always_comb begin
    pick.found   = |cand;
    pick.signo   = idx;
    pick.onehot  = onehot;
    pick.lowmask = onehot | (onehot - 64'd1);
  end

endmodule

### rtl/signal_pending_mask_delivery.sv
// A request is taken while idle and start is high; its word appears on out_word,
// registered from the execute state, with out_valid high for one cycle only.
// A new request is taken only once the previous one has executed; busy is high
// for the cycle in which the action table read returns and the state is updated.
// Reset: synchronous, clears pending and blocked masks, the signalfd mask and
// all action table valid bits at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// signal_pending_mask_delivery
// Signal pending, blocking and delivery unit with a per-signal action table
// held in a synchronous memory.
// ----------------------------------------------------------------------------
`include "signal_pending_mask_delivery_defines.svh"

module signal_pending_mask_delivery #(
  parameter int NUM_SIGNALS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  spmd_pkg::in_word_t   in_word,
  output logic                 out_valid,
  output spmd_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [63:0]          cfg_wdata
);
  import spmd_pkg::*;

  localparam int AW = $clog2(NUM_SIGNALS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] pending_r, pending_nxt;
  logic [63:0] blocked_r, blocked_nxt;
  logic [63:0] custom_r, custom_nxt;
  logic [63:0] sfd_r;
  in_word_t    item_r;
  logic [6:0]  sig_r, sig_nxt;
  logic        ok_r;
  logic        found_r;
  out_word_t   out_r, out_nxt;
  logic        out_valid_r;

  logic        in_accept;
  logic        mem_we;
  act_entry_t  mem_wdata;
  act_entry_t  mem_rdata;
  pick_t       pick;
  logic [63:0] bitg;

  function automatic logic sig_ok(input logic [6:0] s);
    return (s != 7'd0) && (s <= 7'(NUM_SIGNALS));
  endfunction

  assign in_accept = start && (state_r == ST_IDLE);
  assign busy      = (state_r == ST_EXEC);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // Lowest-signal search over the current masks.
  spmd_pick #(
    .NUM_SIGNALS(NUM_SIGNALS)
  ) u_pick (
    .pending (pending_r),
    .blocked (blocked_r),
    .custom  (custom_r),
    .pick    (pick)
  );

  // Signal that the request works on, in guest numbering.
  always_comb begin
    unique case (in_word.kind)
      K_HOST:  sig_nxt = host_to_guest(in_word.signo);
      K_PICK:  sig_nxt = pick.signo;
      default: sig_nxt = in_word.signo;
    endcase
  end

  // Action table; read at acceptance, written back in the execute cycle.
  assign mem_wdata = '{handler_kind: item_r.handler_kind, nodefer: item_r.nodefer,
                       mask: item_r.mask_value};

  spmd_act_mem #(
    .NUM_SIGNALS(NUM_SIGNALS)
  ) u_act_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (AW'(sig_r - 7'd1)),
    .wdata (mem_wdata),
    .re    (in_accept),
    .raddr (AW'(sig_nxt - 7'd1)),
    .rdata (mem_rdata)
  );

  assign bitg = sig_bit(sig_r);

  // State update and result word for the request in the execute cycle.
  always_comb begin
    pending_nxt = pending_r;
    blocked_nxt = blocked_r;
    custom_nxt  = custom_r;
    mem_we      = 1'b0;
    out_nxt     = '0;
    unique case (item_r.kind)
      K_SET: begin
        if (ok_r) begin
          mem_we     = (state_r == ST_EXEC);
          custom_nxt = item_r.handler_kind[1] ? (custom_r | bitg) : (custom_r & ~bitg);
        end
      end
      K_HOST: begin
        if (ok_r) begin
          pending_nxt = pending_r | bitg;
          if (|(sfd_r & bitg)) begin
            out_nxt.event_res = EV_NOTIFY;
            out_nxt.out_signo = sig_r;
          end
        end
      end
      K_RAISE: begin
        if (ok_r) begin
          if (mem_rdata.handler_kind[1]) begin
            pending_nxt = pending_r | bitg;
          end else if (mem_rdata.handler_kind == HK_IGNORE) begin
            pending_nxt = pending_r;
          end else if (|(blocked_r & bitg)) begin
            pending_nxt = pending_r | bitg;
            if (|(sfd_r & bitg)) begin
              out_nxt.event_res = EV_NOTIFY;
              out_nxt.out_signo = sig_r;
            end
          end else if (sig_r == SIG_CHLD || sig_r == SIG_CONT ||
                       sig_r == SIG_URG || sig_r == SIG_WINCH) begin
            pending_nxt = pending_r;
          end else begin
            out_nxt.event_res = EV_TERM;
            out_nxt.out_signo = sig_r;
            out_nxt.term_code = EXIT_BASE + {1'b0, sig_r};
          end
        end
      end
      K_PICK: begin
        // Drop every pending unblocked signal up to and including the chosen one.
        pending_nxt = pending_r & ~(pending_r & ~blocked_r & pick.lowmask);
        if (found_r) begin
          blocked_nxt = blocked_r | mem_rdata.mask | (mem_rdata.nodefer ? 64'd0 : bitg);
          out_nxt.event_res = EV_DELIVER;
          out_nxt.out_signo = sig_r;
        end
      end
      K_RESTORE: begin
        blocked_nxt = item_r.mask_value;
      end
      default: begin
        pending_nxt = pending_r;
      end
    endcase
    out_nxt.blocked_now = blocked_nxt;
  end

  // Sequencer.
  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = in_accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pending_r   <= '0;
      blocked_r   <= '0;
      custom_r    <= '0;
      sfd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_EXEC);
      if (cfg_we) begin
        sfd_r <= cfg_wdata;
      end
      if (state_r == ST_EXEC) begin
        pending_r <= pending_nxt;
        blocked_r <= blocked_nxt;
        custom_r  <= custom_nxt;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r  <= in_word;
      sig_r   <= sig_nxt;
      ok_r    <= sig_ok(sig_nxt);
      found_r <= pick.found;
    end
    if (state_r == ST_EXEC) begin
      out_r <= out_nxt;
    end
  end

  // Checks on sequencing and result encoding.
  `SPMD_ASSERT_NXT(a_accept_exec, clk, rst_n, in_accept, state_r == ST_EXEC, "accept without execute")
  `SPMD_ASSERT_NXT(a_exec_strobe, clk, rst_n, state_r == ST_EXEC, out_valid_r && state_r == ST_IDLE, "execute without result")
  `SPMD_ASSERT_IMP(a_term_code, clk, rst_n, out_valid_r && out_r.event_res == EV_TERM, out_r.term_code == {1'b1, out_r.out_signo}, "bad termination code")
  `SPMD_ASSERT_IMP(a_quiet_zero, clk, rst_n, out_valid_r && out_r.event_res == EV_NONE, out_r.out_signo == 7'd0 && out_r.term_code == 8'd0, "stray signal on quiet result")

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the signal pending, blocking and delivery unit
// Runs a scripted set of requests covering the field extremes and every special
// case, then several phases of random requests under different signalfd routing
// masks. Every result word is checked field by field against its script row, if
// fixed, or an in-bench model of the pending set, blocked mask and action table.
// ----------------------------------------------------------------------------
module tb;
  import spmd_pkg::*;

  // Codes that the package does not name.
  localparam logic [1:0] HK_CUSTOM     = 2'd2;
  localparam logic [1:0] HK_CUSTOM_ALT = 2'd3;
  localparam logic [2:0] K_SPARE_LO    = 3'd5;

  localparam int NSIG           = 64;
  localparam int PHASES         = 5;
  localparam int ITEMS_PER_PHASE = 205;
  // A stall this long is far beyond any sender gap and means a hang.
  localparam int STALL_LIMIT    = 1000;

  typedef struct {
    in_word_t  word;
    bit        fixed;
    out_word_t want;
  } script_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  in_word_t    in_word   = '0;
  logic        out_valid;
  out_word_t   out_word;
  logic        cfg_we    = 1'b0;
  logic [63:0] cfg_wdata = '0;

  // Model state: pending set, blocked mask, routing mask and action table.
  logic [63:0] pend_set;
  logic [63:0] block_set;
  logic [63:0] fd_route;
  logic [1:0]  hand_kind [NSIG];
  logic        no_defer  [NSIG];
  logic [63:0] hand_mask [NSIG];

  out_word_t   awaited_words [$];
  script_row_t script [$];

  int fail_count  = 0;
  int n_sent      = 0;
  int n_checked   = 0;
  int n_delivered = 0;
  int n_killed    = 0;
  int n_notified  = 0;
  int n_routes    = 0;
  int burst_left  = 0;
  int quiet_cycles = 0;

  signal_pending_mask_delivery #(
    .NUM_SIGNALS(NSIG)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mask bit owned by a signal: signal s sits at bit s-1.
  function automatic logic [63:0] bit_of(input logic [6:0] s);
    return 64'd1 << (s - 7'd1);
  endfunction

  // Applies one request to the model state and returns the word it should give.
  function automatic out_word_t step_signal_state(input in_word_t w);
    out_word_t   r;
    logic [6:0]  g;
    logic [63:0] b;
    logic        hit;
    int          idx;
    r = '0;
    idx = int'(w.signo) - 1;
    case (w.kind)
      K_SET: begin
        if (w.signo != 7'd0 && w.signo <= 7'(NSIG)) begin
          hand_kind[idx] = w.handler_kind;
          no_defer[idx]  = w.nodefer;
          hand_mask[idx] = w.mask_value;
        end
      end
      K_HOST: begin
        // Host numbers below 32 are renumbered; the rest keep their number.
        case (w.signo)
          7'd10:   g = 7'd7;
          7'd12:   g = 7'd31;
          7'd16:   g = 7'd23;
          7'd17:   g = 7'd19;
          7'd18:   g = 7'd20;
          7'd19:   g = 7'd18;
          7'd20:   g = 7'd17;
          7'd23:   g = 7'd29;
          7'd30:   g = 7'd10;
          7'd31:   g = 7'd12;
          default: g = w.signo;
        endcase
        if (g != 7'd0 && g <= 7'(NSIG)) begin
          b = bit_of(g);
          pend_set |= b;
          if ((fd_route & b) != 0) begin
            r.event_res = EV_NOTIFY;
            r.out_signo = g;
          end
        end
      end
      K_RAISE: begin
        if (w.signo != 7'd0 && w.signo <= 7'(NSIG)) begin
          b = bit_of(w.signo);
          // A custom handler always pends; an ignored signal does nothing.
          if (hand_kind[idx] > HK_IGNORE) begin
            pend_set |= b;
          end else if (hand_kind[idx] == HK_DEFAULT) begin
            if ((block_set & b) != 0) begin
              pend_set |= b;
              if ((fd_route & b) != 0) begin
                r.event_res = EV_NOTIFY;
                r.out_signo = w.signo;
              end
            end else if (w.signo != SIG_CHLD && w.signo != SIG_CONT &&
                         w.signo != SIG_URG && w.signo != SIG_WINCH) begin
              r.event_res = EV_TERM;
              r.out_signo = w.signo;
              r.term_code = EXIT_BASE + 8'(w.signo);
            end
          end
        end
      end
      K_PICK: begin
        // Lowest pending unblocked signal wins; default and ignored ones
        // below it are dropped on the way.
        hit = 1'b0;
        for (int s = 1; s <= NSIG; s++) begin
          b = bit_of(7'(s));
          if (!hit && (pend_set & b) != 0 && (block_set & b) == 0) begin
            pend_set &= ~b;
            if (hand_kind[s-1] > HK_IGNORE) begin
              hit = 1'b1;
              block_set |= hand_mask[s-1];
              if (!no_defer[s-1]) begin
                block_set |= b;
              end
              r.event_res = EV_DELIVER;
              r.out_signo = 7'(s);
            end
          end
        end
      end
      K_RESTORE: begin
        block_set = w.mask_value;
      end
      default: begin
      end
    endcase
    r.blocked_now = block_set;
    return r;
  endfunction

  function automatic in_word_t request(input logic [2:0] k, input logic [6:0] s,
                                       input logic [1:0] hk, input logic nd,
                                       input logic [63:0] mv);
    in_word_t w;
    w.kind         = k;
    w.signo        = s;
    w.handler_kind = hk;
    w.nodefer      = nd;
    w.mask_value   = mv;
    return w;
  endfunction

  function automatic out_word_t outcome(input logic [1:0] ev, input logic [6:0] s,
                                        input logic [7:0] code, input logic [63:0] blk);
    out_word_t o;
    o.event_res   = ev;
    o.out_signo   = s;
    o.term_code   = code;
    o.blocked_now = blk;
    return o;
  endfunction

  task automatic add_row(input in_word_t w, input bit fixed = 1'b0,
                         input out_word_t want = '0);
    script_row_t row;
    row.word  = w;
    row.fixed = fixed;
    row.want  = want;
    script.push_back(row);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // About one bit in eight set, so that deliveries are not starved.
  function automatic logic [63:0] sparse64();
    return rand64() & rand64() & rand64();
  endfunction

  function automatic in_word_t random_request();
    in_word_t w;
    int       r;
    int       m;
    r = $urandom_range(99);
    if (r < 18)      w.kind = K_SET;
    else if (r < 33) w.kind = K_HOST;
    else if (r < 58) w.kind = K_RAISE;
    else if (r < 85) w.kind = K_PICK;
    else if (r < 95) w.kind = K_RESTORE;
    else             w.kind = K_SPARE_LO + 3'($urandom_range(2));
    // Mostly valid signal numbers, now and then out of range.
    m = $urandom_range(99);
    if (m < 5)                  w.signo = (m < 2) ? 7'd0 : 7'($urandom_range(65, 127));
    else if (w.kind == K_HOST)  w.signo = (m < 70) ? 7'($urandom_range(1, 31))
                                                   : 7'($urandom_range(32, 64));
    else                        w.signo = 7'($urandom_range(1, NSIG));
    w.handler_kind = 2'($urandom_range(3));
    w.nodefer      = 1'($urandom_range(1));
    m = $urandom_range(99);
    if (w.kind == K_RESTORE) begin
      if (m < 40)      w.mask_value = sparse64();
      else if (m < 60) w.mask_value = '0;
      else if (m < 70) w.mask_value = '1;
      else             w.mask_value = rand64();
    end else if (w.kind == K_SET) begin
      if (m < 50)      w.mask_value = '0;
      else if (m < 85) w.mask_value = sparse64();
      else             w.mask_value = rand64();
    end else begin
      w.mask_value = rand64();
    end
    return w;
  endfunction

  // Sender gap: mostly none or short, a few long, and now and then a burst.
  task automatic pause_sender();
    int gap;
    int r;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(99);
      if (r < 2)       burst_left = $urandom_range(20, 60);
      else if (r < 55) gap = 0;
      else if (r < 88) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 12);
      else             gap = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offers one word and waits for it to be taken, then records its result.
  task automatic issue(input in_word_t w, input bit fixed, input out_word_t want);
    out_word_t predicted;
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    predicted = step_signal_state(w);
    awaited_words.push_back(fixed ? want : predicted);
    n_sent++;
  endtask

  // Stops sending and lets every outstanding result come back.
  task automatic quiesce();
    start <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic route_to_fd(input logic [63:0] v);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    fd_route = v;
    n_routes++;
  endtask

  // Result checker: every strobed word is matched against the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    out_word_t got;
    if (rst_n && out_valid) begin
      got = out_word;
      if (awaited_words.size() == 0) begin
        $error("result word with nothing outstanding: event %0d signal %0d",
               got.event_res, got.out_signo);
        fail_count++;
      end else begin
        want = awaited_words.pop_front();
        n_checked++;
        if (want.event_res == EV_DELIVER) n_delivered++;
        if (want.event_res == EV_TERM)    n_killed++;
        if (want.event_res == EV_NOTIFY)  n_notified++;
        if (got.event_res !== want.event_res) begin
          $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
          fail_count++;
        end
        if (got.out_signo !== want.out_signo) begin
          $error("out_signo: expected %0d, got %0d", want.out_signo, got.out_signo);
          fail_count++;
        end
        if (got.term_code !== want.term_code) begin
          $error("term_code: expected %0d, got %0d", want.term_code, got.term_code);
          fail_count++;
        end
        if (got.blocked_now !== want.blocked_now) begin
          $error("blocked_now: expected %h, got %h", want.blocked_now, got.blocked_now);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run if neither side moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $error("no word moved for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [63:0] route;
    pend_set  = '0;
    block_set = '0;
    fd_route  = '0;
    for (int i = 0; i < NSIG; i++) begin
      hand_kind[i] = HK_DEFAULT;
      no_defer[i]  = 1'b0;
      hand_mask[i] = '0;
    end

    // Scripted part. Signals 1 and 64 are routed to the signalfd.
    add_row(request(K_RAISE, 7'd1, 2'd0, 1'b0, '0), 1'b1,
            outcome(EV_TERM, 7'd1, 8'd129, '0));
    add_row(request(K_RAISE, 7'd64, 2'd0, 1'b0, '0), 1'b1,
            outcome(EV_TERM, 7'd64, 8'd192, '0));
    // Signals whose default action is to carry on.
    add_row(request(K_RAISE, SIG_CHLD, 2'd0, 1'b0, '0), 1'b1,
            outcome(EV_NONE, 7'd0, 8'd0, '0));
    add_row(request(K_RAISE, SIG_CONT, 2'd0, 1'b0, '0), 1'b1,
            outcome(EV_NONE, 7'd0, 8'd0, '0));
    add_row(request(K_RAISE, SIG_URG, 2'd0, 1'b0, '0), 1'b1,
            outcome(EV_NONE, 7'd0, 8'd0, '0));
    add_row(request(K_RAISE, SIG_WINCH, 2'd0, 1'b0, '0), 1'b1,
            outcome(EV_NONE, 7'd0, 8'd0, '0));
    // Out of range signals and two of the unused kinds.
    add_row(request(K_RAISE, 7'd0, 2'd0, 1'b0, '0), 1'b1,
            outcome(EV_NONE, 7'd0, 8'd0, '0));
    add_row(request(K_RAISE, 7'd127, 2'd0, 1'b0, '0), 1'b1,
            outcome(EV_NONE, 7'd0, 8'd0, '0));
    add_row(request(K_SPARE_LO, 7'd127, HK_CUSTOM_ALT, 1'b1, '1), 1'b1,
            outcome(EV_NONE, 7'd0, 8'd0, '0));
    add_row(request(K_SPARE_LO + 3'd2, 7'd127, HK_CUSTOM_ALT, 1'b1, '1), 1'b1,
            outcome(EV_NONE, 7'd0, 8'd0, '0));
    // Block everything, then raise while blocked.
    add_row(request(K_RESTORE, 7'd0, 2'd0, 1'b0, '1), 1'b1,
            outcome(EV_NONE, 7'd0, 8'd0, '1));
    add_row(request(K_RAISE, 7'd64, 2'd0, 1'b0, '0), 1'b1,
            outcome(EV_NOTIFY, 7'd64, 8'd0, '1));
    add_row(request(K_RAISE, 7'd2, 2'd0, 1'b0, '0), 1'b1,
            outcome(EV_NONE, 7'd0, 8'd0, '1));
    // Host signals: routed, renumbered, zero and above range.
    add_row(request(K_HOST, 7'd1, 2'd0, 1'b0, '0), 1'b1,
            outcome(EV_NOTIFY, 7'd1, 8'd0, '1));
    add_row(request(K_HOST, 7'd12, 2'd0, 1'b0, '0));
    add_row(request(K_HOST, 7'd0, 2'd0, 1'b0, '0), 1'b1,
            outcome(EV_NONE, 7'd0, 8'd0, '1));
    add_row(request(K_HOST, 7'd96, 2'd0, 1'b0, '0), 1'b1,
            outcome(EV_NONE, 7'd0, 8'd0, '1));
    // Action table writes, including handler kind three and a bad signal.
    add_row(request(K_SET, 7'd5, HK_CUSTOM, 1'b0, 64'hF0));
    add_row(request(K_SET, 7'd2, HK_IGNORE, 1'b0, '0));
    add_row(request(K_SET, 7'd64, HK_CUSTOM_ALT, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA));
    add_row(request(K_SET, 7'd0, HK_CUSTOM, 1'b1, '1));
    // Unblock, pend a custom signal and run the delivery checks.
    add_row(request(K_RESTORE, 7'd0, 2'd0, 1'b0, '0), 1'b1,
            outcome(EV_NONE, 7'd0, 8'd0, '0));
    add_row(request(K_RAISE, 7'd5, 2'd0, 1'b0, '0));
    add_row(request(K_PICK, 7'd0, 2'd0, 1'b0, '0));
    add_row(request(K_PICK, 7'd0, 2'd0, 1'b0, '0));
    add_row(request(K_PICK, 7'd0, 2'd0, 1'b0, '0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    route_to_fd(64'h8000_0000_0000_0001);
    foreach (script[i]) begin
      pause_sender();
      issue(script[i].word, script[i].fixed, script[i].want);
    end

    // Random phases, each under its own routing mask.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       route = '1;
        1:       route = '0;
        2:       route = rand64();
        3:       route = 64'h5555_5555_5555_5555;
        default: route = sparse64();
      endcase
      route_to_fd(route);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pause_sender();
        issue(random_request(), 1'b0, '0);
      end
    end

    quiesce();
    $display("Sent %0d requests under %0d routing masks; %0d result words checked.",
             n_sent, n_routes, n_checked);
    $display("Seen: %0d deliveries, %0d terminations, %0d signalfd notifications.",
             n_delivered, n_killed, n_notified);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/spmd_pkg.sv
rtl/spmd_act_mem.sv
rtl/spmd_pick.sv
rtl/signal_pending_mask_delivery.sv
tb/tb.sv
